FILE: hw/rtl/u8dw_pkg.sv
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types, constants and the width class lookup of the UTF-8 decoder
// with display width accounting.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int unsigned WidthBits = 16;
  localparam int unsigned CpBits    = 21;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned HeldDepth = 3;

  localparam logic [CpBits-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpBits-1:0] SoftHyphen  = 21'h0000AD;
  localparam logic [7:0]        EscByte     = 8'h1B;

  typedef enum logic [1:0] {
    CLS_CONTROL,
    CLS_ZERO,
    CLS_SINGLE,
    CLS_DOUBLE
  } width_class_e;

  typedef enum logic [1:0] {
    ESC_NORMAL,
    ESC_HELD,
    ESC_SEQ
  } esc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_TAIL,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DECODE,
    CMD_TAIL,
    CMD_FIN
  } dp_cmd_e;

  typedef struct packed {
    logic q_empty;
    logic last;
    logic seq_open;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [WidthBits-1:0] total;
    logic                 valid;
    logic                 rep;
    width_class_e         cls;
    logic [CpBits-1:0]    cp;
  } res_t;

  localparam int unsigned ZeroSpans = 9;
  localparam int unsigned WideSpans = 24;

  localparam logic [CpBits-1:0] ZeroLo [ZeroSpans] = '{
    21'h0300, 21'h1AB0, 21'h1DC0, 21'h20D0, 21'hFE20, 21'h200B, 21'hFEFF,
    21'hFE00, 21'hE0100
  };
  localparam logic [CpBits-1:0] ZeroHi [ZeroSpans] = '{
    21'h036F, 21'h1AFF, 21'h1DFF, 21'h20FF, 21'hFE2F, 21'h200D, 21'hFEFF,
    21'hFE0F, 21'hE01EF
  };

  localparam logic [CpBits-1:0] WideLo [WideSpans] = '{
    21'h4E00, 21'h3400, 21'h20000, 21'hF900, 21'hAC00, 21'h1100, 21'h3130,
    21'hA960, 21'hD7B0, 21'hFF01, 21'hFFE0, 21'h3000, 21'h3040, 21'h30A0,
    21'h31F0, 21'h3100, 21'h31A0, 21'h3200, 21'h3300, 21'h1F300, 21'h1FA00,
    21'h2600, 21'h2700, 21'h1F1E0
  };
  localparam logic [CpBits-1:0] WideHi [WideSpans] = '{
    21'h9FFF, 21'h4DBF, 21'h323AF, 21'hFAFF, 21'hD7AF, 21'h11FF, 21'h318F,
    21'hA97F, 21'hD7FF, 21'hFF60, 21'hFFE6, 21'h303F, 21'h309F, 21'h30FF,
    21'h31FF, 21'h312F, 21'h31BF, 21'h32FF, 21'h33FF, 21'h1F9FF, 21'h1FAFF,
    21'h26FF, 21'h27BF, 21'h1F1FF
  };

  function automatic width_class_e class_of(logic [CpBits-1:0] cp);
    logic         zero_hit;
    logic         wide_hit;
    width_class_e cls;
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    for (int i = 0; i < ZeroSpans; i++) begin
      if (cp >= ZeroLo[i] && cp <= ZeroHi[i]) zero_hit = 1'b1;
    end
    for (int i = 0; i < WideSpans; i++) begin
      if (cp >= WideLo[i] && cp <= WideHi[i]) wide_hit = 1'b1;
    end
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
      cls = CLS_CONTROL;
    end else if (cp == SoftHyphen) begin
      cls = CLS_SINGLE;
    end else if (zero_hit) begin
      cls = CLS_ZERO;
    end else if (wide_hit) begin
      cls = CLS_DOUBLE;
    end else begin
      cls = CLS_SINGLE;
    end
    return cls;
  endfunction

endpackage

FILE: hw/rtl/u8dw_ctrl.sv
// ----------------------------------------------------------------------------
// u8dw_ctrl
// Sequencer: takes one byte, walks the decode queue, closes the transaction run.
// ----------------------------------------------------------------------------
module u8dw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  u8dw_pkg::dp_status_t   status_i,
  output u8dw_pkg::dp_cmd_e      cmd_o
);
  import u8dw_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.q_empty) begin
          state_d = (status_i.last && status_i.seq_open) ? ST_TAIL : ST_FIN;
        end
      end
      ST_TAIL: begin
        if (status_i.out_free) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    cmd_o     = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o = CMD_LOAD;
      end
      ST_RUN: begin
        if (!status_i.q_empty && status_i.out_free) cmd_o = CMD_DECODE;
      end
      ST_TAIL: begin
        if (status_i.out_free) cmd_o = CMD_TAIL;
      end
      ST_FIN: begin
        if (status_i.out_free) cmd_o = CMD_FIN;
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/u8dw_datapath.sv
// ----------------------------------------------------------------------------
// u8dw_datapath
// Escape filter, byte queue with replay, UTF-8 assembly, width class and
// running total, one pending result and the output register.
// ----------------------------------------------------------------------------
module u8dw_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u8dw_pkg::dp_cmd_e    cmd_i,
  output u8dw_pkg::dp_status_t status_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output u8dw_pkg::res_t       out_res_o,
  output logic                 out_string_end_o,
  output logic                 out_run_last_o
);
  import u8dw_pkg::*;

  logic                 strip_q, strip_d;
  esc_mode_e            esc_q, esc_d;
  logic [7:0]           lead_q, lead_d;
  logic [1:0]           need_q, need_d;
  logic [7:0]           held_q [HeldDepth];
  logic [7:0]           held_d [HeldDepth];
  logic [1:0]           hcnt_q, hcnt_d;
  logic [WidthBits-1:0] wtot_q, wtot_d;
  logic [7:0]           q_q [QDepth];
  logic [7:0]           q_d [QDepth];
  logic [2:0]           qcnt_q, qcnt_d;
  logic                 last_q, last_d;
  res_t                 pend_q, pend_d;
  logic                 pend_vld_q, pend_vld_d;
  res_t                 out_q, out_d;
  logic                 out_se_q, out_se_d;
  logic                 out_rl_q, out_rl_d;
  logic                 out_vld_q, out_vld_d;

  logic [7:0]           front;
  logic [7:0]           h_eff [HeldDepth];
  logic                 seq_done;
  logic                 seq_ok;
  logic [CpBits-1:0]    seq_cp;
  logic                 new_emit;
  logic [CpBits-1:0]    new_cp;
  logic                 new_rep;
  width_class_e         new_cls;
  logic [1:0]           new_add;
  logic [WidthBits:0]   wsum;
  logic [WidthBits-1:0] wnext;
  res_t                 new_res;
  logic                 push;
  res_t                 push_res;
  logic                 push_se;
  logic                 push_rl;
  logic                 out_free;

  function automatic logic is_term(logic [7:0] b);
    return b == "m" || b == "H" || b == "J" || b == "K" ||
           b == "A" || b == "B" || b == "C" || b == "D";
  endfunction

  assign front    = q_q[0];
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < HeldDepth; i++) begin
      h_eff[i] = (hcnt_q == 2'(i)) ? front : held_q[i];
    end
  end

  assign seq_done = (need_q != 2'd0) && (hcnt_q + 2'd1 == need_q);

  always_comb begin
    seq_ok = 1'b1;
    for (int i = 0; i < HeldDepth; i++) begin
      if (2'(i) < need_q && h_eff[i][7:6] != 2'b10) seq_ok = 1'b0;
    end
    case (need_q)
      2'd1:    seq_cp = {10'd0, lead_q[4:0], h_eff[0][5:0]};
      2'd2:    seq_cp = {5'd0, lead_q[3:0], h_eff[0][5:0], h_eff[1][5:0]};
      2'd3:    seq_cp = {lead_q[2:0], h_eff[0][5:0], h_eff[1][5:0], h_eff[2][5:0]};
      default: seq_cp = '0;
    endcase
  end

  // result produced by a decode step or by the open sequence at string end
  always_comb begin
    new_emit = 1'b0;
    new_cp   = Replacement;
    new_rep  = 1'b1;
    if (cmd_i == CMD_TAIL) begin
      new_emit = 1'b1;
    end else if (cmd_i == CMD_DECODE) begin
      if (need_q == 2'd0) begin
        if (!front[7]) begin
          new_emit = 1'b1;
          new_cp   = {13'd0, front};
          new_rep  = 1'b0;
        end else if (front[7:6] == 2'b10 || front[7:3] == 5'b11111) begin
          new_emit = 1'b1;
        end
      end else if (seq_done) begin
        new_emit = 1'b1;
        new_cp   = seq_ok ? seq_cp : Replacement;
        new_rep  = !seq_ok;
      end
    end
  end

  assign new_cls = class_of(new_cp);

  always_comb begin
    case (new_cls)
      CLS_DOUBLE: new_add = 2'd2;
      CLS_SINGLE: new_add = 2'd1;
      default:    new_add = 2'd0;
    endcase
  end

  assign wsum  = {1'b0, wtot_q} + {{(WidthBits-1){1'b0}}, new_add};
  assign wnext = wsum[WidthBits] ? {WidthBits{1'b1}} : wsum[WidthBits-1:0];

  always_comb begin
    new_res.cp    = new_cp;
    new_res.cls   = new_cls;
    new_res.rep   = new_rep;
    new_res.valid = 1'b1;
    new_res.total = wnext;
  end

  always_comb begin
    strip_d = cfg_we_i ? cfg_data_i : strip_q;
    esc_d   = esc_q;
    lead_d  = lead_q;
    need_d  = need_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    wtot_d  = wtot_q;
    q_d     = q_q;
    qcnt_d  = qcnt_q;
    last_d  = last_q;

    unique case (cmd_i)
      CMD_LOAD: begin
        last_d = in_last_i;
        qcnt_d = 3'd0;
        unique case (esc_q)
          ESC_SEQ: begin
            if (is_term(in_byte_i)) esc_d = ESC_NORMAL;
          end
          ESC_HELD: begin
            if (in_byte_i == "[") begin
              esc_d = ESC_SEQ;
            end else begin
              esc_d  = ESC_NORMAL;
              q_d[0] = EscByte;
              if (strip_q && in_byte_i == EscByte && !in_last_i) begin
                esc_d  = ESC_HELD;
                qcnt_d = 3'd1;
              end else begin
                q_d[1] = in_byte_i;
                qcnt_d = 3'd2;
              end
            end
          end
          default: begin
            if (strip_q && in_byte_i == EscByte && !in_last_i) begin
              esc_d = ESC_HELD;
            end else begin
              q_d[0] = in_byte_i;
              qcnt_d = 3'd1;
            end
          end
        endcase
      end
      CMD_DECODE: begin
        for (int i = 0; i < QDepth - 1; i++) q_d[i] = q_q[i+1];
        qcnt_d = qcnt_q - 3'd1;
        if (new_emit) wtot_d = wnext;
        if (need_q == 2'd0) begin
          hcnt_d = 2'd0;
          lead_d = front;
          if (front[7:5] == 3'b110) begin
            need_d = 2'd1;
          end else if (front[7:4] == 4'b1110) begin
            need_d = 2'd2;
          end else if (front[7:3] == 5'b11110) begin
            need_d = 2'd3;
          end else begin
            lead_d = lead_q;
          end
        end else begin
          held_d = h_eff;
          hcnt_d = hcnt_q + 2'd1;
          if (seq_done) begin
            need_d = 2'd0;
            hcnt_d = 2'd0;
            if (!seq_ok) begin
              // replay the held bytes ahead of what is still queued
              qcnt_d = qcnt_q - 3'd1 + {1'b0, need_q};
              case (need_q)
                2'd1:    q_d = '{h_eff[0], q_q[1], q_q[2], q_q[3]};
                2'd2:    q_d = '{h_eff[0], h_eff[1], q_q[1], q_q[2]};
                default: q_d = '{h_eff[0], h_eff[1], h_eff[2], q_q[1]};
              endcase
            end
          end
        end
      end
      CMD_TAIL: begin
        wtot_d = wnext;
        need_d = 2'd0;
        hcnt_d = 2'd0;
      end
      CMD_FIN: begin
        if (last_q) begin
          esc_d  = ESC_NORMAL;
          lead_d = 8'd0;
          need_d = 2'd0;
          hcnt_d = 2'd0;
          wtot_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // one result is held back so the last one of a byte can be flagged
  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    push       = 1'b0;
    push_res   = pend_q;
    push_se    = 1'b0;
    push_rl    = 1'b0;
    if (new_emit) begin
      push       = pend_vld_q;
      pend_d     = new_res;
      pend_vld_d = 1'b1;
    end else if (cmd_i == CMD_FIN) begin
      pend_vld_d = 1'b0;
      if (pend_vld_q) begin
        push    = 1'b1;
        push_se = last_q;
        push_rl = 1'b1;
      end else if (last_q) begin
        push           = 1'b1;
        push_res.cp    = '0;
        push_res.cls   = CLS_CONTROL;
        push_res.rep   = 1'b0;
        push_res.valid = 1'b0;
        push_res.total = wtot_q;
        push_se        = 1'b1;
        push_rl        = 1'b1;
      end
    end
    out_vld_d = push || (out_vld_q && !out_ready_i);
    out_d     = push ? push_res : out_q;
    out_se_d  = push ? push_se : out_se_q;
    out_rl_d  = push ? push_rl : out_rl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q    <= 1'b0;
      esc_q      <= ESC_NORMAL;
      lead_q     <= 8'd0;
      need_q     <= 2'd0;
      hcnt_q     <= 2'd0;
      wtot_q     <= '0;
      qcnt_q     <= 3'd0;
      last_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      strip_q    <= strip_d;
      esc_q      <= esc_d;
      lead_q     <= lead_d;
      need_q     <= need_d;
      hcnt_q     <= hcnt_d;
      wtot_q     <= wtot_d;
      qcnt_q     <= qcnt_d;
      last_q     <= last_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q   <= held_d;
    q_q      <= q_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
    out_se_q <= out_se_d;
    out_rl_q <= out_rl_d;
  end

  assign status_o.q_empty  = (qcnt_q == 3'd0);
  assign status_o.last     = last_q;
  assign status_o.seq_open = (need_q != 2'd0);
  assign status_o.out_free = out_free;

  assign out_valid_o      = out_vld_q;
  assign out_res_o        = out_q;
  assign out_string_end_o = out_se_q;
  assign out_run_last_o   = out_rl_q;

  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= 3'(QDepth))
    else $error("decode queue overflow");

  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q == 2'd0 && hcnt_q == 2'd0) || (hcnt_q < need_q))
    else $error("held count out of range for open sequence");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_LOAD |-> !pend_vld_q && qcnt_q == 3'd0)
    else $error("new byte loaded with work left over");

  a_string_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_FIN && last_q |=> wtot_q == '0 && need_q == 2'd0 && esc_q == ESC_NORMAL)
    else $error("string state not cleared at string end");

endmodule

FILE: hw/rtl/utf8_decode_display_width.sv
// ----------------------------------------------------------------------------
// utf8_decode_display_width
// UTF-8 byte stream decoder with per-codepoint width class and running
// display width of each string.
// ----------------------------------------------------------------------------
// One byte is taken per input transaction, and the block takes the next byte
// only after the current one has been worked through: it loads the byte, runs
// one decode step per queued byte (one byte normally, two when a held ESC is
// released, and one more for every held byte that a bad continuation puts
// back into the four-entry queue, so replays can chain), finds the queue
// empty, takes an extra tail step when a string ends inside an open sequence,
// and hands over the last result. A single decode unit works through the
// byte queue. Results leave through an output register; while a result waits
// there unaccepted, every decode step and the closing steps wait too, so an
// output stall holds the whole byte. The user must write the escape filter
// setting through the cfg channel only while no byte is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module utf8_decode_display_width (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // codepoint, width_class, total_width, run_last
  output logic [1:0]  m_axis_tuser_o,   // replaced, char_valid
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import u8dw_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;
  res_t       res;
  logic       run_last;

  u8dw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  u8dw_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_byte_i        (s_axis_tdata_i),
    .in_last_i        (s_axis_tlast_i),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_res_o        (res),
    .out_string_end_o (m_axis_tlast_o),
    .out_run_last_o   (run_last)
  );

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {run_last, res.total, res.cls, res.cp};
  assign m_axis_tuser_o = {res.valid, res.rep};

endmodule

FILE: tb/utf8_decode_display_width_test.sv
// ----------------------------------------------------------------------------
// utf8_decode_display_width_test
// Self-checking bench for the UTF-8 decoder with display width accounting.
// A directed byte table covers the corner cases: lead byte extremes, invalid
// leads, bad continuations, incomplete strings, escape stripping and end
// markers. It is followed by random strings under both escape settings, with
// bursty input and receiver stalls. Every result is checked field by field
// against a table value if set, else a behavioral decoder model in the bench.
// ----------------------------------------------------------------------------
module utf8_decode_display_width_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u8dw_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned MaxPerByte = 8;
  localparam logic [7:0] CsiOpen = 8'h5B;

  typedef enum logic [1:0] {
    CFG_KEEP,
    CFG_STRIP_ON,
    CFG_STRIP_OFF
  } cfg_op_e;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct packed {
    logic [CpBits-1:0]    cp;
    width_class_e         cls;
    logic                 rep;
    logic                 valid;
    logic [WidthBits-1:0] total;
    logic                 send;
    logic                 rlast;
  } char_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    cfg_op_e    cfg;
    logic       known;
    char_res_t  want;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;   // codepoint, width_class, total_width, run_last
  logic [1:0]  m_axis_tuser_o;   // replaced, char_valid
  logic        m_axis_tlast_o;
  logic        cfg_ready_o;

  utf8_decode_display_width u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  // decoder model state
  logic                 strip_on;
  esc_mode_e            esc_st;
  logic [7:0]           lead_b;
  int unsigned          need_n;
  logic [7:0]           held_b [HeldDepth];
  int unsigned          held_n;
  logic [WidthBits-1:0] col_total;
  char_res_t            step_res [MaxPerByte];
  int unsigned          step_n;

  char_res_t   char_q [$];
  stim_t       tx_q [$];
  rx_mode_e    rx_mode = RX_FREE;
  logic        idle_en = 1'b0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case (rx_mode)
      RX_FREE:     m_tready <= 1'b1;
      RX_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 35);
      RX_PERIODIC: m_tready <= ((cycle_count % 11) < 6);
      default:     m_tready <= 1'b1;
    endcase
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40) begin
      $display("mismatch %s: got 0x%0h expected 0x%0h (result %0d)", what, got,
               want, results_seen);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    char_res_t got;
    char_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.cp    = m_axis_tdata_o[20:0];
      got.cls   = width_class_e'(m_axis_tdata_o[22:21]);
      got.total = m_axis_tdata_o[38:23];
      got.rlast = m_axis_tdata_o[39];
      got.rep   = m_axis_tuser_o[0];
      got.valid = m_axis_tuser_o[1];
      got.send  = m_axis_tlast_o;
      if (char_q.size() == 0) begin
        report_mismatch("unexpected result, codepoint", got.cp, 0);
      end else begin
        want = char_q.pop_front();
        if (got.cp != want.cp) report_mismatch("codepoint", got.cp, want.cp);
        if (got.cls != want.cls) report_mismatch("width_class", got.cls, want.cls);
        if (got.rep != want.rep) report_mismatch("replaced", got.rep, want.rep);
        if (got.valid != want.valid) report_mismatch("char_valid", got.valid, want.valid);
        if (got.total != want.total) report_mismatch("total_width", got.total, want.total);
        if (got.send != want.send) report_mismatch("string_end", got.send, want.send);
        if (got.rlast != want.rlast) report_mismatch("run_last", got.rlast, want.rlast);
      end
      results_seen++;
    end
  end

  function automatic logic in_span(logic [CpBits-1:0] c, int unsigned lo, int unsigned hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic width_class_e class_for(logic [CpBits-1:0] c);
    if (c < 21'h20 || (c >= 21'h7F && c < 21'hA0)) return CLS_CONTROL;
    if (c == 21'hAD) return CLS_SINGLE;
    if (in_span(c, 'h0300, 'h036F) || in_span(c, 'h1AB0, 'h1AFF) ||
        in_span(c, 'h1DC0, 'h1DFF) || in_span(c, 'h20D0, 'h20FF) ||
        in_span(c, 'hFE20, 'hFE2F) || in_span(c, 'h200B, 'h200D) ||
        in_span(c, 'hFEFF, 'hFEFF) || in_span(c, 'hFE00, 'hFE0F) ||
        in_span(c, 'hE0100, 'hE01EF)) return CLS_ZERO;
    if (in_span(c, 'h4E00, 'h9FFF) || in_span(c, 'h3400, 'h4DBF) ||
        in_span(c, 'h20000, 'h323AF) || in_span(c, 'hF900, 'hFAFF) ||
        in_span(c, 'hAC00, 'hD7AF) || in_span(c, 'h1100, 'h11FF) ||
        in_span(c, 'h3130, 'h318F) || in_span(c, 'hA960, 'hA97F) ||
        in_span(c, 'hD7B0, 'hD7FF) || in_span(c, 'hFF01, 'hFF60) ||
        in_span(c, 'hFFE0, 'hFFE6) || in_span(c, 'h3000, 'h303F) ||
        in_span(c, 'h3040, 'h309F) || in_span(c, 'h30A0, 'h30FF) ||
        in_span(c, 'h31F0, 'h31FF) || in_span(c, 'h3100, 'h312F) ||
        in_span(c, 'h31A0, 'h31BF) || in_span(c, 'h3200, 'h32FF) ||
        in_span(c, 'h3300, 'h33FF) || in_span(c, 'h1F300, 'h1F9FF) ||
        in_span(c, 'h1FA00, 'h1FAFF) || in_span(c, 'h2600, 'h26FF) ||
        in_span(c, 'h2700, 'h27BF) || in_span(c, 'h1F1E0, 'h1F1FF)) return CLS_DOUBLE;
    return CLS_SINGLE;
  endfunction

  function automatic void push_char(logic [CpBits-1:0] c, logic rep, logic valid);
    char_res_t r;
    if (step_n < MaxPerByte) begin
      r.cp    = c;
      r.cls   = valid ? class_for(c) : CLS_CONTROL;
      r.rep   = rep;
      r.valid = valid;
      r.total = col_total;
      r.send  = 1'b0;
      r.rlast = 1'b0;
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void emit_char(logic [CpBits-1:0] c, logic rep);
    width_class_e         cls;
    logic [WidthBits:0]   sum;
    cls = class_for(c);
    sum = {1'b0, col_total};
    if (cls == CLS_SINGLE) sum = sum + (WidthBits+1)'(1);
    if (cls == CLS_DOUBLE) sum = sum + (WidthBits+1)'(2);
    col_total = sum[WidthBits] ? {WidthBits{1'b1}} : sum[WidthBits-1:0];
    push_char(c, rep, 1'b1);
  endfunction

  function automatic void decode_feed(logic [7:0] first);
    logic [7:0]        work [$];
    logic [7:0]        b;
    logic [CpBits-1:0] c;
    logic              ok;
    int unsigned       n;
    work.push_back(first);
    while (work.size() > 0) begin
      b = work.pop_front();
      if (need_n == 0) begin
        held_n = 0;
        if (b < 8'h80) begin
          emit_char({13'd0, b}, 1'b0);
        end else if ((b & 8'hE0) == 8'hC0) begin
          lead_b = b;
          need_n = 1;
        end else if ((b & 8'hF0) == 8'hE0) begin
          lead_b = b;
          need_n = 2;
        end else if ((b & 8'hF8) == 8'hF0) begin
          lead_b = b;
          need_n = 3;
        end else begin
          emit_char(Replacement, 1'b1);
        end
      end else begin
        held_b[held_n] = b;
        held_n++;
        if (held_n >= need_n) begin
          n = need_n;
          if (n == 1) c = {16'd0, lead_b[4:0]};
          else if (n == 2) c = {17'd0, lead_b[3:0]};
          else c = {18'd0, lead_b[2:0]};
          ok = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (held_b[i][7:6] != 2'b10) ok = 1'b0;
            c = (c << 6) | held_b[i][5:0];
          end
          need_n = 0;
          held_n = 0;
          if (ok) begin
            emit_char(c, 1'b0);
          end else begin
            emit_char(Replacement, 1'b1);
            for (int i = n - 1; i >= 0; i--) work.push_front(held_b[i]);
          end
        end
      end
    end
  endfunction

  function automatic logic is_csi_end(logic [7:0] b);
    return b == "m" || b == "H" || b == "J" || b == "K" ||
           b == "A" || b == "B" || b == "C" || b == "D";
  endfunction

  function automatic void decode_predict(logic [7:0] b, logic last);
    step_n = 0;
    if (esc_st == ESC_SEQ) begin
      if (is_csi_end(b)) esc_st = ESC_NORMAL;
    end else if (esc_st == ESC_HELD && b == CsiOpen) begin
      esc_st = ESC_SEQ;
    end else begin
      if (esc_st == ESC_HELD) begin
        esc_st = ESC_NORMAL;
        decode_feed(EscByte);
      end
      if (strip_on && b == EscByte && !last) esc_st = ESC_HELD;
      else decode_feed(b);
    end
    if (last) begin
      if (need_n != 0) begin
        need_n = 0;
        held_n = 0;
        emit_char(Replacement, 1'b1);
      end
      if (step_n == 0) push_char('0, 1'b0, 1'b0);
      step_res[step_n-1].send = 1'b1;
      esc_st = ESC_NORMAL;
      lead_b = '0;
      held_n = 0;
      col_total = '0;
    end
    if (step_n > 0) step_res[step_n-1].rlast = 1'b1;
  endfunction

  task automatic take_byte(input stim_t it);
    decode_predict(it.b, it.last);
    if (it.known) begin
      if (step_n != 1) report_mismatch("result count of table row", step_n, 1);
      char_q.push_back(it.want);
    end else begin
      for (int i = 0; i < step_n; i++) char_q.push_back(step_res[i]);
    end
  endtask

  task automatic send_queue();
    for (int i = 0; i < tx_q.size(); i++) begin
      s_tvalid <= 1'b1;
      s_tdata  <= tx_q[i].b;
      s_tlast  <= tx_q[i].last;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      take_byte(tx_q[i]);
      bytes_sent++;
      if (idle_en && burst_left == 0) begin
        s_tvalid <= 1'b0;
        burst_left = $urandom_range(0, 12);
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        if (burst_left > 0) burst_left--;
        if (i == tx_q.size() - 1) begin
          s_tvalid <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
    tx_q.delete();
  endtask

  task automatic drain_results();
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_strip(input logic v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    strip_on = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic char_res_t mk(logic [CpBits-1:0] c, width_class_e cls, logic rep,
                                   logic valid, logic [WidthBits-1:0] total, logic send);
    char_res_t r;
    r = '{cp: c, cls: cls, rep: rep, valid: valid, total: total, send: send, rlast: 1'b1};
    return r;
  endfunction

  function automatic stim_t row(logic [7:0] b, logic last, cfg_op_e cfg);
    stim_t s;
    s = '{b: b, last: last, cfg: cfg, known: 1'b0, want: '0};
    return s;
  endfunction

  function automatic stim_t row_k(logic [7:0] b, char_res_t want);
    stim_t s;
    s = row(b, want.send, CFG_KEEP);
    s.known = 1'b1;
    s.want  = want;
    return s;
  endfunction

  localparam int unsigned DirRows = 28;

  function automatic stim_t directed_row(int unsigned idx);
    case (idx)
      0:  return row_k(8'h41, mk(21'h41, CLS_SINGLE, 1'b0, 1'b1, 16'd1, 1'b0));
      1:  return row_k(8'h00, mk(21'h00, CLS_CONTROL, 1'b0, 1'b1, 16'd1, 1'b0));
      2:  return row_k(8'h7F, mk(21'h7F, CLS_CONTROL, 1'b0, 1'b1, 16'd1, 1'b0));
      3:  return row_k(8'hFF, mk(Replacement, CLS_SINGLE, 1'b1, 1'b1, 16'd2, 1'b0));
      4:  return row_k(8'h80, mk(Replacement, CLS_SINGLE, 1'b1, 1'b1, 16'd3, 1'b0));
      5:  return row(8'hC2, 1'b0, CFG_KEEP);
      6:  return row(8'hAD, 1'b0, CFG_KEEP);
      7:  return row(8'hE4, 1'b0, CFG_KEEP);
      8:  return row(8'hB8, 1'b0, CFG_KEEP);
      9:  return row(8'h80, 1'b0, CFG_KEEP);
      10: return row(8'hF0, 1'b0, CFG_KEEP);
      11: return row(8'h9F, 1'b0, CFG_KEEP);
      12: return row(8'h8C, 1'b0, CFG_KEEP);
      13: return row(8'h80, 1'b0, CFG_KEEP);
      14: return row(8'hC3, 1'b0, CFG_KEEP);
      15: return row(8'h41, 1'b0, CFG_KEEP);
      16: return row(8'hE4, 1'b1, CFG_KEEP);
      17: return row(8'hF8, 1'b1, CFG_KEEP);
      18: return row(8'h1B, 1'b0, CFG_STRIP_ON);
      19: return row(8'h5B, 1'b0, CFG_KEEP);
      20: return row(8'h33, 1'b0, CFG_KEEP);
      21: return row(8'h6D, 1'b0, CFG_KEEP);
      22: return row(8'h78, 1'b1, CFG_KEEP);
      23: return row(8'h1B, 1'b0, CFG_KEEP);
      24: return row(8'h5A, 1'b0, CFG_KEEP);
      25: return row(8'h1B, 1'b0, CFG_KEEP);
      26: return row(8'h5B, 1'b0, CFG_KEEP);
      default: return row_k(8'h4B, mk('0, CLS_CONTROL, 1'b0, 1'b0, 16'd1, 1'b1));
    endcase
  endfunction

  function automatic void put_byte(logic [7:0] b);
    tx_q.push_back(row(b, 1'b0, CFG_KEEP));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void add_random_char();
    int unsigned k;
    int unsigned n;
    logic [7:0]  terms [8];
    terms = '{"m", "H", "J", "K", "A", "B", "C", "D"};
    k = $urandom_range(0, 99);
    if (k < 22) begin
      put_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (k < 28) begin
      put_byte(($urandom_range(0, 7) == 0) ? 8'h7F : 8'($urandom_range(0, 31)));
    end else if (k < 40) begin
      put_byte(8'($urandom_range(8'hC2, 8'hDF)));
      put_byte(cont_byte());
    end else if (k < 50) begin
      put_byte(8'($urandom_range(8'hE0, 8'hEF)));
      put_byte(cont_byte());
      put_byte(cont_byte());
    end else if (k < 57) begin
      put_byte(8'($urandom_range(8'hE4, 8'hE9)));
      put_byte(cont_byte());
      put_byte(cont_byte());
    end else if (k < 62) begin
      case ($urandom_range(0, 2))
        0: begin put_byte(8'hCC); put_byte(cont_byte()); end
        1: begin put_byte(8'hE2); put_byte(8'h80); put_byte(8'($urandom_range(8'h8B, 8'h8D))); end
        default: begin put_byte(8'hEF); put_byte(8'hB8); put_byte(8'($urandom_range(8'h80, 8'h8F))); end
      endcase
    end else if (k < 70) begin
      put_byte(8'($urandom_range(8'hF0, 8'hF4)));
      put_byte(cont_byte());
      put_byte(cont_byte());
      put_byte(cont_byte());
    end else if (k < 82) begin
      put_byte(EscByte);
      if ($urandom_range(0, 9) < 8) begin
        put_byte(CsiOpen);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) put_byte(($urandom_range(0, 3) == 0) ? ";" : 8'($urandom_range("0", "9")));
        put_byte(terms[$urandom_range(0, 7)]);
      end else if ($urandom_range(0, 1) == 1) begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end else if (k < 92) begin
      // truncated sequence, often followed by a byte that breaks it
      n = $urandom_range(1, 3);
      put_byte((n == 1) ? 8'($urandom_range(8'hC0, 8'hDF)) :
               (n == 2) ? 8'($urandom_range(8'hE0, 8'hEF)) : 8'($urandom_range(8'hF0, 8'hF7)));
      for (int i = 1; i < n; i++) begin
        if ($urandom_range(0, 2) != 0) put_byte(cont_byte());
      end
      if ($urandom_range(0, 3) != 0) begin
        put_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8'h7F))
                                             : 8'($urandom_range(8'hC0, 8'hFF)));
      end
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void close_string();
    stim_t it;
    it = tx_q.pop_back();
    it.last = 1'b1;
    tx_q.push_back(it);
  endfunction

  initial begin
    stim_t it;
    int unsigned chars;
    strip_on  = 1'b0;
    esc_st    = ESC_NORMAL;
    lead_b    = '0;
    need_n    = 0;
    held_n    = 0;
    col_total = '0;
    for (int i = 0; i < HeldDepth; i++) held_b[i] = '0;

    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    idle_en = 1'b1;
    rx_mode = RX_RANDOM;
    for (int r = 0; r < DirRows; r++) begin
      it = directed_row(r);
      if (it.cfg == CFG_STRIP_ON) write_strip(1'b1);
      if (it.cfg == CFG_STRIP_OFF) write_strip(1'b0);
      tx_q.push_back(it);
      send_queue();
    end
    write_strip(1'b0);

    // random strings, several settings
    for (int ph = 0; ph < 6; ph++) begin
      rx_mode = rx_mode_e'(ph % 3);
      idle_en = (ph != 2);
      write_strip((ph % 2) == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      while (tx_q.size() < 60) begin
        chars = $urandom_range(1, 8);
        for (int c = 0; c < chars; c++) add_random_char();
        if (tx_q.size() < 60 || $urandom_range(0, 99) < 85) close_string();
      end
      send_queue();
    end

    drain_results();
    $display("sent %0d bytes, checked %0d results, %0d escape filter writes",
             bytes_sent, results_seen, cfg_writes);
    $display("covered the directed table and random strings with escapes under gaps and stalls");
    if (char_q.size() != 0) report_mismatch("results missing", 0, char_q.size());
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: utf8_decode_display_width.f
hw/rtl/u8dw_pkg.sv
hw/rtl/u8dw_ctrl.sv
hw/rtl/u8dw_datapath.sv
hw/rtl/utf8_decode_display_width.sv
tb/utf8_decode_display_width_test.sv
